// ===== rtl/hc_pkg.sv =====
package hc_pkg;

  localparam int WORD_W    = 32;
  localparam int IDX_W     = 9;
  localparam int CNT_W     = 10;
  localparam int EXP_W     = 11;
  localparam int POS_W     = 5;
  localparam int BLK_IDX_W = 4;

  localparam int TABLE_DEPTH = 512;
  localparam int BLOCK_WORDS = 16;

  localparam logic [EXP_W-1:0] EXP_FIRST    = 11'd16;
  localparam logic [EXP_W-1:0] EXP_P_FIRST  = 11'd256;
  localparam logic [EXP_W-1:0] EXP_LAST     = 11'd1279;
  localparam logic [CNT_W-1:0] WARM_LAST    = 10'd1023;
  localparam logic [CNT_W-1:0] BLK_LAST     = 10'd15;
  localparam logic [POS_W-1:0] POS_EMPTY    = 5'd16;

  localparam logic       OP_INIT = 1'b0;
  localparam logic       OP_DATA = 1'b1;

  localparam logic [1:0] CFG_KEY_LOW  = 2'd0;
  localparam logic [1:0] CFG_KEY_HIGH = 2'd1;
  localparam logic [1:0] CFG_IV_LOW   = 2'd2;
  localparam logic [1:0] CFG_IV_HIGH  = 2'd3;

  typedef struct packed {
    logic              we;
    logic              sel_q;
    logic [IDX_W-1:0]  addr;
    logic [WORD_W-1:0] data;
  } exp_wr_t;

  typedef struct packed {
    logic start;
    logic replace;
    logic clear;
  } step_req_t;

  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] out;
  } step_rsp_t;

endpackage

// ===== rtl/hc128_stream_cipher_core.sv =====
// Init request: table expansion, then 1024 table steps, each run in phases
// through the single read port per table.
// Data request: result registered in the cycle after acceptance while
// keystream words remain; otherwise a fresh block of 16 steps comes first.
// Reset (rst_n, synchronous, active low) clears control, key and IV; tables
// hold nothing valid until an init request.
module hc128_stream_cipher_core import hc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // data_word[31:0], bytes_valid[34:32], zero pad
  input  logic        in_tuser,   // op
  input  logic        in_tlast,   // end_of_message
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // result_word[31:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  typedef enum logic [2:0] {S_IDLE, S_EXPAND, S_WARM, S_GEN, S_DELIVER} state_t;

  state_t            state_r, state_nxt;
  logic [POS_W-1:0]  bpos_r, bpos_nxt;
  logic [CNT_W-1:0]  nstep_r, nstep_nxt;
  logic [WORD_W-1:0] ks_r [BLOCK_WORDS];
  logic [63:0]       key_low_r, key_high_r, iv_low_r, iv_high_r;
  logic [WORD_W-1:0] word_r, word_nxt;
  logic [2:0]        nvalid_r, nvalid_nxt;
  logic              eom_r, eom_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0] out_data_r, out_data_nxt;
  logic              start_r, start_nxt, rep_r, rep_nxt;
  logic              clear_r, clear_nxt, kstart_r, kstart_nxt;

  logic              in_acc, out_free, ks_we, produce;
  logic [WORD_W-1:0] res_word, mask;
  logic [2:0]        res_nv;
  logic              res_eom;
  logic [WORD_W-1:0] ks_word;
  logic              kdone;
  exp_wr_t           ewr;
  step_req_t         sreq;
  step_rsp_t         srsp;

  assign cfg_ready  = 1'b1;
  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE) && out_free;
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign sreq.start   = start_r;
  assign sreq.replace = rep_r;
  assign sreq.clear   = clear_r;

  hc_kexp u_kexp (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (kstart_r),
    .key_low  (key_low_r),
    .key_high (key_high_r),
    .iv_low   (iv_low_r),
    .iv_high  (iv_high_r),
    .wr       (ewr),
    .done     (kdone)
  );

  hc_step u_step (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (sreq),
    .ewr   (ewr),
    .rsp   (srsp)
  );

  always_comb begin
    state_nxt     = state_r;
    bpos_nxt      = bpos_r;
    nstep_nxt     = nstep_r;
    word_nxt      = word_r;
    nvalid_nxt    = nvalid_r;
    eom_nxt       = eom_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    start_nxt     = 1'b0;
    rep_nxt       = rep_r;
    clear_nxt     = 1'b0;
    kstart_nxt    = 1'b0;
    ks_we         = 1'b0;
    produce       = 1'b0;
    res_word      = word_r;
    res_nv        = nvalid_r;
    res_eom       = eom_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_tuser == OP_INIT) begin
            kstart_nxt = 1'b1;
            clear_nxt  = 1'b1;
            bpos_nxt   = POS_EMPTY;
            state_nxt  = S_EXPAND;
          end else if (bpos_r == POS_EMPTY) begin
            word_nxt   = in_tdata[31:0];
            nvalid_nxt = in_tdata[34:32];
            eom_nxt    = in_tlast;
            nstep_nxt  = '0;
            start_nxt  = 1'b1;
            rep_nxt    = 1'b0;
            state_nxt  = S_GEN;
          end else begin
            res_word = in_tdata[31:0];
            res_nv   = in_tdata[34:32];
            res_eom  = in_tlast;
            produce  = 1'b1;
          end
        end
      end
      S_EXPAND: begin
        if (kdone) begin
          nstep_nxt = '0;
          start_nxt = 1'b1;
          rep_nxt   = 1'b1;
          state_nxt = S_WARM;
        end
      end
      S_WARM: begin
        if (srsp.done) begin
          if (nstep_r == WARM_LAST) begin
            state_nxt = S_IDLE;
          end else begin
            nstep_nxt = nstep_r + 10'd1;
            start_nxt = 1'b1;
          end
        end
      end
      S_GEN: begin
        if (srsp.done) begin
          ks_we = 1'b1;
          if (nstep_r == BLK_LAST) begin
            bpos_nxt  = '0;
            state_nxt = S_DELIVER;
          end else begin
            nstep_nxt = nstep_r + 10'd1;
            start_nxt = 1'b1;
          end
        end
      end
      S_DELIVER: begin
        if (out_free) begin
          produce   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    case (res_nv)
      3'd0:    mask = 32'h0000_0000;
      3'd1:    mask = 32'h0000_00ff;
      3'd2:    mask = 32'h0000_ffff;
      3'd3:    mask = 32'h00ff_ffff;
      default: mask = 32'hffff_ffff;
    endcase
    ks_word = ks_r[bpos_nxt[BLK_IDX_W-1:0]];

    if (produce) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = (res_word ^ ks_word) & mask;
      if (res_eom || res_nv < 3'd4) begin
        bpos_nxt = POS_EMPTY;
      end else begin
        bpos_nxt = bpos_nxt + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      bpos_r      <= POS_EMPTY;
      nstep_r     <= '0;
      out_valid_r <= 1'b0;
      start_r     <= 1'b0;
      rep_r       <= 1'b0;
      clear_r     <= 1'b0;
      kstart_r    <= 1'b0;
      key_low_r   <= '0;
      key_high_r  <= '0;
      iv_low_r    <= '0;
      iv_high_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      bpos_r      <= bpos_nxt;
      nstep_r     <= nstep_nxt;
      out_valid_r <= out_valid_nxt;
      start_r     <= start_nxt;
      rep_r       <= rep_nxt;
      clear_r     <= clear_nxt;
      kstart_r    <= kstart_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_KEY_LOW:  key_low_r  <= cfg_data;
          CFG_KEY_HIGH: key_high_r <= cfg_data;
          CFG_IV_LOW:   iv_low_r   <= cfg_data;
          CFG_IV_HIGH:  iv_high_r  <= cfg_data;
          default: ;
        endcase
      end
    end
    word_r     <= word_nxt;
    nvalid_r   <= nvalid_nxt;
    eom_r      <= eom_nxt;
    out_data_r <= out_data_nxt;
    if (ks_we) begin
      ks_r[nstep_r[BLK_IDX_W-1:0]] <= srsp.out;
    end
  end

endmodule

// ===== rtl/hc_ram.sv =====
module hc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/hc_kexp.sv =====
module hc_kexp import hc_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [63:0]   key_low,
  input  logic [63:0]   key_high,
  input  logic [63:0]   iv_low,
  input  logic [63:0]   iv_high,
  output exp_wr_t       wr,
  output logic          done
);

  logic [WORD_W-1:0] win_r [16];
  logic [EXP_W-1:0]  i_r;
  logic              busy_r;
  logic              done_r;
  logic [WORD_W-1:0] w_new;
  logic [EXP_W-1:0]  addr_full;

  function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] x, input int n);
    rotr = (x >> n) | (x << (WORD_W - n));
  endfunction

  always_comb begin
    w_new = (rotr(win_r[14], 17) ^ rotr(win_r[14], 19) ^ (win_r[14] >> 10))
          + win_r[9]
          + (rotr(win_r[1], 7) ^ rotr(win_r[1], 18) ^ (win_r[1] >> 3))
          + win_r[0]
          + {{(WORD_W-EXP_W){1'b0}}, i_r};
    addr_full = i_r - EXP_P_FIRST;
    wr.we    = busy_r && (i_r >= EXP_P_FIRST);
    wr.sel_q = i_r[EXP_W-1:IDX_W] != 2'b00 && i_r >= 11'd768;
    wr.addr  = addr_full[IDX_W-1:0];
    wr.data  = w_new;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      i_r    <= EXP_FIRST;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        i_r    <= EXP_FIRST;
        for (int k = 0; k < 2; k++) begin
          win_r[4*k+0] <= key_low[31:0];
          win_r[4*k+1] <= key_low[63:32];
          win_r[4*k+2] <= key_high[31:0];
          win_r[4*k+3] <= key_high[63:32];
          win_r[4*k+8] <= iv_low[31:0];
          win_r[4*k+9] <= iv_low[63:32];
          win_r[4*k+10] <= iv_high[31:0];
          win_r[4*k+11] <= iv_high[63:32];
        end
      end else if (busy_r) begin
        for (int k = 0; k < 15; k++) begin
          win_r[k] <= win_r[k+1];
        end
        win_r[15] <= w_new;
        i_r       <= i_r + 11'd1;
        if (i_r == EXP_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;

endmodule

// ===== rtl/hc_step.sv =====
module hc_step import hc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  step_req_t req,
  input  exp_wr_t   ewr,
  output step_rsp_t rsp
);

  logic [CNT_W-1:0]  cnt_r;
  logic [2:0]        ph_r;
  logic              busy_r;
  logic              rep_r;
  logic              done_r;
  logic [WORD_W-1:0] out_r;
  logic [WORD_W-1:0] a3_r, a511_r, a10_r, tjn_r, x_r, lo_r;

  logic              tsel;
  logic [IDX_W-1:0]  j, t_raddr, o_raddr;
  logic [WORD_W-1:0] rd_p, rd_q, rd_t, rd_o, g, out_w, wval;
  logic              swe;
  logic              p_we, q_we;
  logic [IDX_W-1:0]  waddr, p_raddr, q_raddr;
  logic [WORD_W-1:0] wdata;

  function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] x, input int n);
    rotr = (x >> n) | (x << (WORD_W - n));
  endfunction

  function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x, input int n);
    rotl = (x << n) | (x >> (WORD_W - n));
  endfunction

  always_comb begin
    tsel = cnt_r[CNT_W-1];
    j    = cnt_r[IDX_W-1:0];
    case (ph_r)
      3'd0:    t_raddr = j - 9'd3;
      3'd1:    t_raddr = j + 9'd1;
      3'd2:    t_raddr = j - 9'd10;
      3'd3:    t_raddr = j;
      3'd4:    t_raddr = j - 9'd12;
      default: t_raddr = j;
    endcase
    rd_t = tsel ? rd_q : rd_p;
    rd_o = tsel ? rd_p : rd_q;
    if (ph_r == 3'd5) begin
      o_raddr = {1'b0, rd_t[7:0]};
    end else begin
      o_raddr = {1'b1, x_r[23:16]};
    end
    if (tsel) begin
      g = (rotl(a3_r, 10) ^ rotl(a511_r, 23)) + rotl(a10_r, 8);
    end else begin
      g = (rotr(a3_r, 10) ^ rotr(a511_r, 23)) + rotr(a10_r, 8);
    end
    out_w   = (lo_r + rd_o) ^ tjn_r;
    wval    = rep_r ? out_w : tjn_r;
    swe     = busy_r && (ph_r == 3'd7);
    p_we    = (ewr.we && !ewr.sel_q) || (swe && !tsel);
    q_we    = (ewr.we && ewr.sel_q) || (swe && tsel);
    waddr   = ewr.we ? ewr.addr : j;
    wdata   = ewr.we ? ewr.data : wval;
    p_raddr = tsel ? o_raddr : t_raddr;
    q_raddr = tsel ? t_raddr : o_raddr;
  end

  hc_ram #(.WIDTH(WORD_W), .DEPTH(TABLE_DEPTH)) u_p_ram (
    .clk   (clk),
    .we    (p_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (p_raddr),
    .rdata (rd_p)
  );

  hc_ram #(.WIDTH(WORD_W), .DEPTH(TABLE_DEPTH)) u_q_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (q_raddr),
    .rdata (rd_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ph_r   <= 3'd0;
      cnt_r  <= '0;
      done_r <= 1'b0;
      rep_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.clear) begin
        cnt_r <= '0;
      end
      if (!busy_r && req.start) begin
        busy_r <= 1'b1;
        ph_r   <= 3'd0;
        rep_r  <= req.replace;
      end else if (busy_r) begin
        ph_r <= ph_r + 3'd1;
        case (ph_r)
          3'd1:    a3_r   <= rd_t;
          3'd2:    a511_r <= rd_t;
          3'd3:    a10_r  <= rd_t;
          3'd4:    tjn_r  <= rd_t + g;
          3'd5:    x_r    <= rd_t;
          3'd6:    lo_r   <= rd_o;
          3'd7: begin
            busy_r <= 1'b0;
            cnt_r  <= cnt_r + 10'd1;
            done_r <= 1'b1;
            out_r  <= out_w;
          end
          default: ;
        endcase
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.out  = out_r;

endmodule
